// ----- rtl/msi_pkg.sv -----
// Shared types and constants of the motor safety interlock.
package msi_pkg;

   // Field widths of the item channels.
   localparam int TIME_W     = 32;
   localparam int CH0_W      = 11;
   localparam int DRIVE_W    = 36;
   localparam int ROLLER_W   = 36;
   localparam int AUX_W      = 18;
   localparam int TIMEOUT_W  = 16;
   localparam int LIMIT_W    = 8;

   // PWM lane layout.
   localparam int PWM_BITS      = 9;
   localparam int DRIVE_LANES   = 4;
   localparam int ROLLER_LANES  = 4;
   localparam int AUX_LANES     = 2;
   localparam int DRIVE_EXT_W   = (DRIVE_LANES * PWM_BITS > DRIVE_W) ?
                                  DRIVE_LANES * PWM_BITS : DRIVE_W;
   localparam int ROLLER_EXT_W  = (ROLLER_LANES * PWM_BITS > ROLLER_W) ?
                                  ROLLER_LANES * PWM_BITS : ROLLER_W;
   localparam int AUX_EXT_W     = (AUX_LANES * PWM_BITS > AUX_W) ?
                                  AUX_LANES * PWM_BITS : AUX_W;

   // Blink divider: bit 0 of now / BLINK_HALF_MS by a rounded-up reciprocal.
   localparam int          BLINK_HALF_MS = 300;
   localparam int          BLINK_SHIFT   = $clog2(BLINK_HALF_MS);
   localparam int          BLINK_POST    = TIME_W + BLINK_SHIFT;
   localparam logic [63:0] BLINK_RECIP   =
      ((64'd1 << BLINK_POST) + 64'(BLINK_HALF_MS) - 64'd1) / 64'(BLINK_HALF_MS);
   localparam logic [15:0] BLINK_RECIP_LO = BLINK_RECIP[15:0];
   localparam logic [16:0] BLINK_RECIP_HI = BLINK_RECIP[32:16];
   localparam int          PLO_W          = TIME_W + 16;
   localparam int          PHI_W          = TIME_W + 17;
   localparam int          PSUM_W         = PHI_W + 17;

   // Team LED color codes.
   localparam logic TEAM_RED  = 1'b0;
   localparam logic TEAM_BLUE = 1'b1;

   // Register reset values.
   localparam logic [TIMEOUT_W-1:0] RADIO_TIMEOUT_RST = 16'd100;
   localparam logic [TIMEOUT_W-1:0] CAN_TIMEOUT_RST   = 16'd100;
   localparam logic [LIMIT_W-1:0]   ROLLER_LIMIT_RST  = 8'd100;
   localparam logic                 TEAM_SIDE_RST     = TEAM_RED;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_RADIO_TIMEOUT,
      REG_CAN_TIMEOUT,
      REG_ROLLER_LIMIT,
      REG_TEAM_SIDE
   } reg_index_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [TIMEOUT_W-1:0] radio_timeout_ms;
      logic [TIMEOUT_W-1:0] can_timeout_ms;
      logic [LIMIT_W-1:0]   roller_limit;
      logic                 team_side;
   } cfg_type;

endpackage

// ----- rtl/msi_lane.sv -----
// PWM lane: clamps it to the roller limit if enabled and flags a positive value.
module msi_lane
   import msi_pkg::*;
(
   input  logic [PWM_BITS-1:0] lane_in,
   input  logic                clamp_en,
   input  logic [LIMIT_W-1:0]  limit,
   output logic [PWM_BITS-1:0] lane_out,
   output logic                positive
);

   localparam int CMP_W = ((PWM_BITS > LIMIT_W) ? PWM_BITS : LIMIT_W) + 1;

   logic [CMP_W-1:0] lane_ext;
   logic [CMP_W-1:0] limit_ext;
   logic             over;

   // Signed lane against the unsigned limit, both widened to a common width.
   assign lane_ext  = CMP_W'($signed(lane_in));
   assign limit_ext = {{(CMP_W - LIMIT_W){1'b0}}, limit};
   assign over      = $signed(lane_ext) > $signed(limit_ext);

   // With clamp_en, a lane above the limit drops to it; nothing is ever raised.
   assign lane_out = (clamp_en && over) ? limit_ext[PWM_BITS-1:0] : lane_in;

   // Lane strictly above zero.
   assign positive = !lane_in[PWM_BITS-1] && (|lane_in);

endmodule

// ----- rtl/msi_csr.sv -----
// Configuration registers of the interlock behind an APB-style port.
module msi_csr
   import msi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type wr_index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign wr_index   = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register update on the access cycle of a write.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_RADIO_TIMEOUT: cfg_in.radio_timeout_ms = csr_pwdata[TIMEOUT_W-1:0];
            REG_CAN_TIMEOUT:   cfg_in.can_timeout_ms   = csr_pwdata[TIMEOUT_W-1:0];
            REG_ROLLER_LIMIT:  cfg_in.roller_limit     = csr_pwdata[LIMIT_W-1:0];
            REG_TEAM_SIDE:     cfg_in.team_side        = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radio_timeout_ms <= RADIO_TIMEOUT_RST;
         cfg_ff.can_timeout_ms   <= CAN_TIMEOUT_RST;
         cfg_ff.roller_limit     <= ROLLER_LIMIT_RST;
         cfg_ff.team_side        <= TEAM_SIDE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data follows the addressed register.
   always_comb begin
      case (wr_index)
         REG_RADIO_TIMEOUT: csr_prdata = 32'(cfg_ff.radio_timeout_ms);
         REG_CAN_TIMEOUT:   csr_prdata = 32'(cfg_ff.can_timeout_ms);
         REG_ROLLER_LIMIT:  csr_prdata = 32'(cfg_ff.roller_limit);
         REG_TEAM_SIDE:     csr_prdata = 32'(cfg_ff.team_side);
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/motor_safety_interlock_core.sv -----
// Top level of the motor safety interlock: link checks, PWM lanes and LEDs.
//
// Each req_ item is one control period and passes the first-stage and
// output registers before its result leaves on the rsp_ channel: the first
// stage judges the radio and CAN links and starts the blink divider (two
// partial products of a reciprocal multiply), the second stage zeroes or
// clamps the ten PWM lanes in parallel lane units, merges the drive-lane
// results and forms the LEDs. The block takes one item per clock cycle while
// rsp_stall stays low. When rsp_stall is high the finished result holds; one
// more item can still enter an empty first stage, after which req_stall rises
// until the result is taken. Configuration is written through the csr_ port;
// pready is always high and registers sit at byte addresses 0, 4, 8 and 12.
// Reset is synchronous: it empties both stages and loads the register
// defaults (timeouts 100 ms, roller limit 100, red team).
module motor_safety_interlock_core
   import msi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Item input channel.
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [TIME_W-1:0]    req_now_ms,
   input  logic [TIME_W-1:0]    req_radio_last_rx_ms,
   input  logic [TIME_W-1:0]    req_can_last_rx_ms,
   input  logic                 req_radio_failsafe,
   input  logic                 req_radio_lost_frame,
   input  logic [CH0_W-1:0]     req_radio_channel_zero,
   input  logic                 req_lidar_lost,
   input  logic                 req_roller_ready_in,
   input  logic [DRIVE_W-1:0]   req_drive_pwm_in,
   input  logic [ROLLER_W-1:0]  req_roller_pwm_in,
   input  logic [AUX_W-1:0]     req_aux_pwm_in,
   // Result channel.
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DRIVE_W-1:0]   rsp_drive_pwm_out,
   output logic [ROLLER_W-1:0]  rsp_roller_pwm_out,
   output logic [AUX_W-1:0]     rsp_aux_pwm_out,
   output logic                 rsp_roller_ready_out,
   output logic                 rsp_radio_error,
   output logic                 rsp_can_fault,
   output logic                 rsp_status_green,
   output logic                 rsp_status_blue,
   output logic                 rsp_status_red,
   output logic                 rsp_team_red,
   output logic                 rsp_team_blue,
   // Configuration port.
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   typedef struct packed {
      logic [PLO_W-1:0]    plo;
      logic [PHI_W-1:0]    phi;
      logic                radio_err;
      logic                can_err;
      logic                lidar;
      logic                ready;
      logic [DRIVE_W-1:0]  drive;
      logic [ROLLER_W-1:0] roller;
      logic [AUX_W-1:0]    aux;
   } s1_type;

   typedef struct packed {
      logic [DRIVE_W-1:0]  drive;
      logic [ROLLER_W-1:0] roller;
      logic [AUX_W-1:0]    aux;
      logic                ready;
      logic                radio_err;
      logic                can_err;
      logic                green;
      logic                sblue;
      logic                sred;
      logic                tred;
      logic                tblue;
   } rsp_type;

   cfg_type cfg;

   logic    s1_valid_ff, s1_valid_in;
   s1_type  s1_ff, s1_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    s1_load, rsp_load;

   msi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Flow control: each stage loads when it is empty or moves on.
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || rsp_load;
   assign req_stall = !s1_load;

   // First stage: link judgements and the blink partial products.
   logic [TIME_W-1:0] radio_age, can_age;

   assign radio_age = req_now_ms - req_radio_last_rx_ms;
   assign can_age   = req_now_ms - req_can_last_rx_ms;

   always_comb begin
      s1_in.plo       = PLO_W'(req_now_ms) * PLO_W'(BLINK_RECIP_LO);
      s1_in.phi       = PHI_W'(req_now_ms) * PHI_W'(BLINK_RECIP_HI);
      s1_in.radio_err = (radio_age > TIME_W'(cfg.radio_timeout_ms)) ||
                        req_radio_failsafe || req_radio_lost_frame ||
                        (req_radio_channel_zero == '0);
      s1_in.can_err   = can_age > TIME_W'(cfg.can_timeout_ms);
      s1_in.lidar     = req_lidar_lost;
      s1_in.ready     = req_roller_ready_in;
      s1_in.drive     = req_drive_pwm_in;
      s1_in.roller    = req_roller_pwm_in;
      s1_in.aux       = req_aux_pwm_in;
   end

   assign s1_valid_in = s1_load ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= s1_in;
      end
   end

   // Second stage: blink bit from the summed partial products.
   logic [PSUM_W-1:0] psum;
   logic              blink;
   logic              any_err;

   assign psum    = (PSUM_W'(s1_ff.phi) << 16) + PSUM_W'(s1_ff.plo);
   assign blink   = psum[BLINK_POST];
   assign any_err = s1_ff.radio_err || s1_ff.can_err;

   // Link loss zeroes every lane of each field.
   logic [DRIVE_EXT_W-1:0]  drive_base, drive_ext;
   logic [ROLLER_EXT_W-1:0] roller_base, roller_ext;
   logic [AUX_EXT_W-1:0]    aux_base, aux_ext;

   assign drive_base  = any_err ? '0 : DRIVE_EXT_W'(s1_ff.drive);
   assign roller_base = any_err ? '0 : ROLLER_EXT_W'(s1_ff.roller);
   assign aux_base    = any_err ? '0 : AUX_EXT_W'(s1_ff.aux);

   // Lane units working side by side.
   logic [PWM_BITS-1:0] drive_lane   [DRIVE_LANES];
   logic [PWM_BITS-1:0] roller_lane  [ROLLER_LANES];
   logic [PWM_BITS-1:0] aux_lane     [AUX_LANES];
   logic [DRIVE_LANES-1:0]  drive_pos;
   logic [ROLLER_LANES-1:0] roller_pos;
   logic [AUX_LANES-1:0]    aux_pos;
   logic                    driving;

   for (genvar k = 0; k < DRIVE_LANES; k++) begin : g_drive
      msi_lane u_lane (
         .lane_in  (drive_base[k*PWM_BITS +: PWM_BITS]),
         .clamp_en (1'b0),
         .limit    (cfg.roller_limit),
         .lane_out (drive_lane[k]),
         .positive (drive_pos[k])
      );
   end

   // Merge: any drive lane above zero enables the roller clamp.
   assign driving = |drive_pos;

   for (genvar k = 0; k < ROLLER_LANES; k++) begin : g_roller
      msi_lane u_lane (
         .lane_in  (roller_base[k*PWM_BITS +: PWM_BITS]),
         .clamp_en (driving),
         .limit    (cfg.roller_limit),
         .lane_out (roller_lane[k]),
         .positive (roller_pos[k])
      );
   end

   for (genvar k = 0; k < AUX_LANES; k++) begin : g_aux
      msi_lane u_lane (
         .lane_in  (aux_base[k*PWM_BITS +: PWM_BITS]),
         .clamp_en (1'b0),
         .limit    (cfg.roller_limit),
         .lane_out (aux_lane[k]),
         .positive (aux_pos[k])
      );
   end

   // Put the lane results back in place; the lanes fill each whole field.
   always_comb begin
      drive_ext  = drive_base;
      roller_ext = roller_base;
      aux_ext    = aux_base;
      for (int k = 0; k < DRIVE_LANES; k++) begin
         drive_ext[k*PWM_BITS +: PWM_BITS] = drive_lane[k];
      end
      for (int k = 0; k < ROLLER_LANES; k++) begin
         roller_ext[k*PWM_BITS +: PWM_BITS] = roller_lane[k];
      end
      for (int k = 0; k < AUX_LANES; k++) begin
         aux_ext[k*PWM_BITS +: PWM_BITS] = aux_lane[k];
      end
   end

   // Status and team LEDs.
   logic ready_eff, team_on;

   assign ready_eff = s1_ff.ready && !any_err;
   assign team_on   = ready_eff ? blink : 1'b1;

   always_comb begin
      rsp_in.drive     = drive_ext[DRIVE_W-1:0];
      rsp_in.roller    = roller_ext[ROLLER_W-1:0];
      rsp_in.aux       = aux_ext[AUX_W-1:0];
      rsp_in.ready     = ready_eff;
      rsp_in.radio_err = s1_ff.radio_err;
      rsp_in.can_err   = s1_ff.can_err;
      rsp_in.green     = any_err ? 1'b0 : (s1_ff.lidar ? blink : 1'b1);
      rsp_in.sblue     = s1_ff.radio_err && blink;
      rsp_in.sred      = s1_ff.can_err && blink;
      if (any_err) begin
         rsp_in.tred  = s1_ff.can_err && blink;
         rsp_in.tblue = s1_ff.radio_err && blink;
      end else if (cfg.team_side == TEAM_RED) begin
         rsp_in.tred  = team_on;
         rsp_in.tblue = 1'b0;
      end else begin
         rsp_in.tred  = 1'b0;
         rsp_in.tblue = team_on;
      end
   end

   // Output register.
   assign rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive_pwm_out    = rsp_ff.drive;
   assign rsp_roller_pwm_out   = rsp_ff.roller;
   assign rsp_aux_pwm_out      = rsp_ff.aux;
   assign rsp_roller_ready_out = rsp_ff.ready;
   assign rsp_radio_error      = rsp_ff.radio_err;
   assign rsp_can_fault        = rsp_ff.can_err;
   assign rsp_status_green     = rsp_ff.green;
   assign rsp_status_blue      = rsp_ff.sblue;
   assign rsp_status_red       = rsp_ff.sred;
   assign rsp_team_red         = rsp_ff.tred;
   assign rsp_team_blue        = rsp_ff.tblue;

endmodule
